>>> hw/rtl/dxt1_pkg.sv
package dxt1_pkg;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } color_t;

    typedef color_t [3:0] palette_t;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // Widen an RGB565 word to 8 bits per channel by bit replication; alpha opaque.
    function automatic color_t expand565(input logic [15:0] w);
        color_t c;
        c.r = {w[15:11], w[15:13]};
        c.g = {w[10:5], w[10:9]};
        c.b = {w[4:0], w[4:2]};
        c.a = ALPHA_OPAQUE;
        return c;
    endfunction

endpackage

>>> hw/rtl/dxt1_block_decoder_with_smoothing.sv
// DXT1-style 4x4 block decoder with 2x2 smoothing. Each block transfer on the
// input channel yields sixteen pixel transfers in row-major order, pixel_pos
// counting 0 to 15 and last_pixel set on the sixteenth. On acceptance the
// four-color palette is built and held together with the index bits; a 4-bit
// pixel counter then walks the block, one pixel per unstalled cycle, looking up the
// pixel and its right, lower and lower-right neighbors in the held palette
// and applying the 26/14/14/10 weights (over 64) for rows and columns 0-2.
// Throughput is one pixel per cycle while out_stall is low; the next
// block is accepted in the cycle the last pixel of the current one moves to
// the output register, so back-to-back blocks stream without gaps. The
// ext_colors_enable register (APB address 0, bit 0) selects the raw 8-bit
// endpoints in bytes 8-15 if nonzero; change it only while no block is in flight.
module dxt1_block_decoder_with_smoothing (
    input  logic        clk,
    input  logic        rst_n,
    // block input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] endpoint_a,
    input  logic [15:0] endpoint_b,
    input  logic [31:0] index_bits,
    input  logic [31:0] ext_word_a,
    input  logic [31:0] ext_word_b,
    // pixel output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  pixel_pos,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        last_pixel,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dxt1_pkg::*;

    localparam logic       ADDR_EXT_EN = 1'b0;
    localparam logic [3:0] POS_LAST    = 4'd15;

    // configuration register
    logic ext_en_reg;

    // held block
    logic        blk_valid_reg;
    palette_t    pal_reg;
    logic [31:0] idx_reg;
    logic [3:0]  cnt_reg;

    // output register
    logic        out_valid_reg;
    logic [3:0]  pos_reg;
    color_t      pix_reg;
    logic        last_reg;

    palette_t    pal_next;
    logic        in_take;
    logic        advance;
    logic        blk_done;
    logic        cfg_write;
    color_t      pix_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == ADDR_EXT_EN);
    assign prdata    = (paddr[2] == ADDR_EXT_EN) ? {31'd0, ext_en_reg} : 32'd0;

    dxt1_palette u_palette (
        .ext_en     (ext_en_reg),
        .endpoint_a (endpoint_a),
        .endpoint_b (endpoint_b),
        .index_bits (index_bits),
        .ext_word_a (ext_word_a),
        .ext_word_b (ext_word_b),
        .palette    (pal_next)
    );

    // Advance the counter while a block is held and the output register is free or being drained.
    assign advance  = blk_valid_reg && (!out_valid_reg || !out_stall);
    assign blk_done = advance && (cnt_reg == POS_LAST);
    assign in_stall = blk_valid_reg && !blk_done;
    assign in_take  = in_valid && !in_stall;

    // Palette index of pixel q sits at bits 2q+1:2q of the index word.
    function automatic color_t lookup(input palette_t pal, input logic [31:0] idx,
                                      input logic [3:0] q);
        logic [1:0] sel;
        sel = idx[{q, 1'b0} +: 2];
        return pal[sel];
    endfunction

    function automatic logic [7:0] smooth(input logic [7:0] s, input logic [7:0] rt,
                                          input logic [7:0] dn, input logic [7:0] dr);
        logic [13:0] acc;
        acc = 14'(s) * 14'd26 + 14'(rt) * 14'd14 + 14'(dn) * 14'd14 + 14'(dr) * 14'd10;
        return acc[13:6];
    endfunction

    always_comb
    begin
        color_t c_self;
        color_t c_right;
        color_t c_down;
        color_t c_diag;
        c_self  = lookup(pal_reg, idx_reg, cnt_reg);
        c_right = lookup(pal_reg, idx_reg, cnt_reg + 4'd1);
        c_down  = lookup(pal_reg, idx_reg, cnt_reg + 4'd4);
        c_diag  = lookup(pal_reg, idx_reg, cnt_reg + 4'd5);
        // right column and bottom row pass through unfiltered
        if ((cnt_reg[3:2] != 2'd3) && (cnt_reg[1:0] != 2'd3))
        begin
            pix_next.r = smooth(c_self.r, c_right.r, c_down.r, c_diag.r);
            pix_next.g = smooth(c_self.g, c_right.g, c_down.g, c_diag.g);
            pix_next.b = smooth(c_self.b, c_right.b, c_down.b, c_diag.b);
            pix_next.a = smooth(c_self.a, c_right.a, c_down.a, c_diag.a);
        end
        else
        begin
            pix_next = c_self;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_en_reg    <= 1'b0;
            blk_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                ext_en_reg <= pwdata[0];
            end

            if (in_take)
            begin
                blk_valid_reg <= 1'b1;
                cnt_reg       <= 4'd0;
            end
            else if (advance)
            begin
                blk_valid_reg <= !blk_done;
                cnt_reg       <= cnt_reg + 4'd1;
            end

            // hold the output while stalled, drop it once transferred
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pal_reg <= pal_next;
            idx_reg <= index_bits;
        end
        if (advance)
        begin
            pos_reg  <= cnt_reg;
            pix_reg  <= pix_next;
            last_reg <= (cnt_reg == POS_LAST);
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_pos  = pos_reg;
    assign red        = pix_reg.r;
    assign green      = pix_reg.g;
    assign blue       = pix_reg.b;
    assign alpha      = pix_reg.a;
    assign last_pixel = last_reg;

endmodule

>>> hw/rtl/dxt1_palette.sv
module dxt1_palette (
    input  logic               ext_en,
    input  logic [15:0]        endpoint_a,
    input  logic [15:0]        endpoint_b,
    input  logic [31:0]        index_bits,
    input  logic [31:0]        ext_word_a,
    input  logic [31:0]        ext_word_b,
    output dxt1_pkg::palette_t palette
);
    import dxt1_pkg::*;

    function automatic logic [7:0] avg8(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[8:1];
    endfunction

    // (11x + 5y) >> 4
    function automatic logic [7:0] blend(input logic [7:0] x, input logic [7:0] y);
        logic [11:0] s;
        s = 12'(x) * 12'd11 + 12'(y) * 12'd5;
        return s[11:4];
    endfunction

    logic   use_ext;
    logic   a_le_b;
    logic   flat;
    color_t col_a;
    color_t col_b;
    color_t col_2;
    color_t col_3;
    color_t col_flat;

    assign use_ext = ext_en && ((ext_word_a | ext_word_b) != 32'd0);
    assign a_le_b  = endpoint_a <= endpoint_b;
    assign flat    = (endpoint_a == endpoint_b)
                  && (index_bits[7:0] == index_bits[15:8])
                  && (index_bits[15:8] == index_bits[23:16])
                  && (index_bits[23:16] == index_bits[31:24]);

    always_comb
    begin
        col_a = expand565(endpoint_a);
        col_b = expand565(endpoint_b);
        if (use_ext)
        begin
            col_a.r = ext_word_a[7:0];
            col_a.g = ext_word_a[15:8];
            col_a.b = ext_word_a[23:16];
            col_b.r = ext_word_b[7:0];
            col_b.g = ext_word_b[15:8];
            col_b.b = ext_word_b[23:16];
        end

        if (a_le_b)
        begin
            col_2.r = avg8(col_a.r, col_b.r);
            col_2.g = avg8(col_a.g, col_b.g);
            col_2.b = avg8(col_a.b, col_b.b);
            col_2.a = ALPHA_OPAQUE;
            col_3   = col_2;
            col_3.a = ALPHA_CLEAR;
        end
        else
        begin
            col_2.r = blend(col_a.r, col_b.r);
            col_2.g = blend(col_a.g, col_b.g);
            col_2.b = blend(col_a.b, col_b.b);
            col_2.a = ALPHA_OPAQUE;
            col_3.r = blend(col_b.r, col_a.r);
            col_3.g = blend(col_b.g, col_a.g);
            col_3.b = blend(col_b.b, col_a.b);
            col_3.a = ALPHA_OPAQUE;
        end

        // flat block: all entries are A; alpha clear if all indices are 3
        col_flat   = col_a;
        col_flat.a = (index_bits[7:0] == 8'hFF) ? ALPHA_CLEAR : ALPHA_OPAQUE;

        if (flat)
        begin
            palette = {col_flat, col_flat, col_flat, col_flat};
        end
        else
        begin
            palette = {col_3, col_2, col_b, col_a};
        end
    end

endmodule
